/* sv/apn_pkg.sv */
`default_nettype none
package apn_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 32;
  localparam int unsigned IDX_W               = 5;
  localparam logic [5:0]  EMPTY_DISTANCE      = 6'd63;
  localparam logic [5:0]  THRESH_RESET        = 6'd4;

  typedef struct packed {
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
  } color_t;

  // search item walking down the cell row
  typedef struct packed {
    logic       active;
    color_t     color;
    logic [5:0] best;
    logic [5:0] pen;
    logic       found;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    color_t           data;
  } wr_t;

  function automatic logic [3:0] absdiff(input logic [3:0] a, input logic [3:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [5:0] l1dist(input color_t a, input color_t e);
    return {2'b00, absdiff(a.r, e.r)} + {2'b00, absdiff(a.g, e.g)}
         + {2'b00, absdiff(a.b, e.b)};
  endfunction

endpackage
`default_nettype wire

/* sv/apn_ifs.sv */
`default_nettype none
interface apn_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [3:0] red;
  logic [3:0] green;
  logic [3:0] blue;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, output ready);
endinterface

interface apn_res_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_x;
  logic [9:0] out_y;
  logic [5:0] pen;
  logic [5:0] distance;
  logic       allocated;
  logic [4:0] new_index;
  logic [3:0] new_red;
  logic [3:0] new_green;
  logic [3:0] new_blue;

  modport source (output valid, out_x, out_y, pen, distance, allocated, new_index,
                  new_red, new_green, new_blue, input ready);
  modport sink   (input valid, out_x, out_y, pen, distance, allocated, new_index,
                  new_red, new_green, new_blue, output ready);
endinterface

interface apn_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] match_threshold;

  modport source (output valid, match_threshold, input ready);
  modport sink   (input valid, match_threshold, output ready);
endinterface
`default_nettype wire

/* sv/apn_cell.sv */
`default_nettype none
module apn_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire apn_pkg::token_t  tok_i,
  input  wire apn_pkg::wr_t     wr_i,
  input  wire logic [CNT_W-1:0] count_i,
  output apn_pkg::token_t       tok_o
);
  import apn_pkg::*;

  color_t     entry_r;
  token_t     tok_r;
  token_t     tok_nxt;
  logic [5:0] d1;
  logic [5:0] d2;
  logic       live;
  color_t     half;

  assign half = '{r: {1'b0, entry_r.r[3:1]}, g: {1'b0, entry_r.g[3:1]},
                  b: {1'b0, entry_r.b[3:1]}};
  assign d1   = l1dist(tok_i.color, entry_r);
  assign d2   = l1dist(tok_i.color, half);
  assign live = CNT_W'(INDEX) < count_i;

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.active && live) begin
      if (!tok_i.found || d1 < tok_i.best) begin
        tok_nxt.best  = d1;
        tok_nxt.pen   = {1'b0, IDX_W'(INDEX)};
        tok_nxt.found = 1'b1;
      end
      if (d2 < tok_nxt.best) begin
        tok_nxt.best = d2;
        tok_nxt.pen  = {1'b1, IDX_W'(INDEX)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
    if (wr_i.en && wr_i.idx == IDX_W'(INDEX)) begin
      entry_r <= wr_i.data;
    end
  end

  assign tok_o = tok_r;
endmodule
`default_nettype wire

/* sv/adaptive_palette_nearest_pen.sv */
// An accepted pixel walks the cell row one palette entry per cycle, is held in
// fin_r and waits in EMIT until the result register is free; a new item enters
// only after the result.
// Reset (rst_n low, synchronous): palette empty, threshold 4, no result pending.
`default_nettype none
module adaptive_palette_nearest_pen #(
  parameter int unsigned PALETTE_ENTRIES = apn_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  apn_pix_if.sink   in_ch,
  apn_res_if.source out_ch,
  apn_cfg_if.sink   cfg_ch
);
  import apn_pkg::*;

  localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES + 1);

  typedef enum logic [1:0] {IDLE, SEARCH, EMIT} state_t;

  state_t           state_r;
  token_t           launch_r;
  token_t           fin_r;
  logic [9:0]       x_r;
  logic [9:0]       y_r;
  logic [CNT_W-1:0] count_r;
  logic [5:0]       thr_r;
  token_t           tok [PALETTE_ENTRIES+1];
  wr_t              wr;

  logic             out_valid_r;
  logic [9:0]       out_x_r;
  logic [9:0]       out_y_r;
  logic [5:0]       pen_r;
  logic [5:0]       dist_r;
  logic             alloc_r;
  logic [4:0]       nidx_r;
  color_t           ncol_r;

  logic [5:0]       best_fin;
  logic             room;
  logic             alloc;
  logic             small_col;
  color_t           store_col;
  logic [IDX_W-1:0] idx_new;
  logic             emit_go;

  assign tok[0] = launch_r;

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    apn_cell #(.INDEX(k), .CNT_W(CNT_W)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (tok[k]),
      .wr_i    (wr),
      .count_i (count_r),
      .tok_o   (tok[k+1])
    );
  end

  assign best_fin  = fin_r.found ? fin_r.best : EMPTY_DISTANCE;
  assign room      = count_r < CNT_W'(PALETTE_ENTRIES);
  assign alloc     = (best_fin > thr_r) && room;
  assign small_col = !fin_r.color.r[3] && !fin_r.color.g[3] && !fin_r.color.b[3];
  assign store_col = small_col ? '{r: {fin_r.color.r[2:0], 1'b0},
                                   g: {fin_r.color.g[2:0], 1'b0},
                                   b: {fin_r.color.b[2:0], 1'b0}} : fin_r.color;
  assign idx_new   = IDX_W'(count_r);
  assign emit_go   = (state_r == EMIT) && (!out_valid_r || out_ch.ready);

  assign wr.en   = emit_go && alloc;
  assign wr.idx  = idx_new;
  assign wr.data = store_col;

  assign in_ch.ready  = (state_r == IDLE);
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= IDLE;
      launch_r.active <= 1'b0;
      count_r         <= '0;
      thr_r           <= THRESH_RESET;
      out_valid_r     <= 1'b0;
    end else begin
      launch_r.active <= 1'b0;
      if (cfg_ch.valid) begin
        thr_r <= cfg_ch.match_threshold;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_ch.valid) begin
            launch_r.active <= 1'b1;
            launch_r.color  <= '{r: in_ch.red, g: in_ch.green, b: in_ch.blue};
            launch_r.best   <= '0;
            launch_r.pen    <= '0;
            launch_r.found  <= 1'b0;
            x_r             <= in_ch.pixel_x;
            y_r             <= in_ch.pixel_y;
            state_r         <= SEARCH;
          end
        end
        SEARCH: begin
          if (tok[PALETTE_ENTRIES].active) begin
            fin_r   <= tok[PALETTE_ENTRIES];
            state_r <= EMIT;
          end
        end
        EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            dist_r      <= best_fin;
            alloc_r     <= alloc;
            if (alloc) begin
              pen_r   <= {small_col, idx_new};
              nidx_r  <= idx_new;
              ncol_r  <= store_col;
              count_r <= count_r + CNT_W'(1);
            end else begin
              pen_r   <= fin_r.pen;
              nidx_r  <= '0;
              ncol_r  <= '0;
            end
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.pen       = pen_r;
  assign out_ch.distance  = dist_r;
  assign out_ch.allocated = alloc_r;
  assign out_ch.new_index = nidx_r;
  assign out_ch.new_red   = ncol_r.r;
  assign out_ch.new_green = ncol_r.g;
  assign out_ch.new_blue  = ncol_r.b;
endmodule
`default_nettype wire

/* tb/palette_match_checker.sv */
`default_nettype none
module palette_match_checker #(
  parameter int unsigned PALETTE_ENTRIES = apn_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  apn_pix_if        pix,
  apn_res_if        res,
  apn_cfg_if        cfg,
  output int        fail_count,
  output int        outstanding,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import apn_pkg::*;

  localparam int HALF_BRITE_PEN = 32;

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [5:0] pen;
    logic [5:0] distance;
    logic       allocated;
    logic [4:0] new_index;
    color_t     stored;
  } pen_pick_t;

  color_t      palette [PALETTE_ENTRIES];
  int          entry_count;
  logic [5:0]  threshold;
  pen_pick_t   awaited_picks [$];
  pen_pick_t   want;
  pen_pick_t   got;
  int          fails;
  int          seen;

  function automatic int color_gap(input color_t a, input color_t b);
    int dr, dg, db;
    dr = int'(a.r) - int'(b.r);
    dg = int'(a.g) - int'(b.g);
    db = int'(a.b) - int'(b.b);
    return (dr < 0 ? -dr : dr) + (dg < 0 ? -dg : dg) + (db < 0 ? -db : db);
  endfunction

  function automatic pen_pick_t match_pixel(input logic [9:0] x, input logic [9:0] y,
                                            input color_t shade);
    pen_pick_t pick;
    color_t    full;
    color_t    half;
    int        best, pen, d_full, d_half, n, i;
    pick = '0;
    pick.x = x;
    pick.y = y;
    n = (entry_count > int'(PALETTE_ENTRIES)) ? int'(PALETTE_ENTRIES) : entry_count;
    best = int'(EMPTY_DISTANCE);
    pen = 0;
    for (i = 0; i < n; i++) begin
      full = palette[i];
      half = {full.r >> 1, full.g >> 1, full.b >> 1};
      d_full = color_gap(shade, full);
      d_half = color_gap(shade, half);
      if (i == 0 || d_full < best) begin
        best = d_full;
        pen = i;
      end
      if (d_half < best) begin
        best = d_half;
        pen = i + HALF_BRITE_PEN;
      end
    end
    if (best > int'(threshold) && n < int'(PALETTE_ENTRIES)) begin
      pick.allocated = 1'b1;
      pick.new_index = 5'(n);
      // dark colors go in doubled and are drawn with the half-brite pen
      if (shade.r < 4'd8 && shade.g < 4'd8 && shade.b < 4'd8) begin
        pick.stored = {shade.r << 1, shade.g << 1, shade.b << 1};
        pen = n + HALF_BRITE_PEN;
      end else begin
        pick.stored = shade;
        pen = n;
      end
    end
    pick.pen = 6'(pen);
    pick.distance = 6'(best);
    return pick;
  endfunction

  task automatic compare_field(input string name, input logic [9:0] exp_v,
                               input logic [9:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_picks.delete();
      entry_count = 0;
      threshold = THRESH_RESET;
    end else begin
      if (cfg.valid && cfg.ready)
        threshold = cfg.match_threshold;
      if (pix.valid && pix.ready) begin
        want = match_pixel(pix.pixel_x, pix.pixel_y, {pix.red, pix.green, pix.blue});
        awaited_picks.push_back(want);
        if (want.allocated) begin
          palette[want.new_index] = want.stored;
          entry_count++;
        end
      end
      if (res.valid && res.ready) begin
        got = {res.out_x, res.out_y, res.pen, res.distance, res.allocated, res.new_index,
               res.new_red, res.new_green, res.new_blue};
        seen++;
        if (awaited_picks.size() == 0) begin
          $display("%0t: unexpected item, expected none, got x=%0d y=%0d pen=%0d", $time,
                   got.x, got.y, got.pen);
          fails++;
        end else begin
          want = awaited_picks.pop_front();
          compare_field("out_x", want.x, got.x);
          compare_field("out_y", want.y, got.y);
          compare_field("pen", 10'(want.pen), 10'(got.pen));
          compare_field("distance", 10'(want.distance), 10'(got.distance));
          compare_field("allocated", 10'(want.allocated), 10'(got.allocated));
          compare_field("new_index", 10'(want.new_index), 10'(got.new_index));
          compare_field("new_red", 10'(want.stored.r), 10'(got.stored.r));
          compare_field("new_green", 10'(want.stored.g), 10'(got.stored.g));
          compare_field("new_blue", 10'(want.stored.b), 10'(got.stored.b));
        end
      end
    end
    outstanding <= awaited_picks.size();
    fail_count <= fails;
    checked <= seen;
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import apn_pkg::*;

  localparam int unsigned ENTRIES     = PALETTE_ENTRIES_DEF;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          PHASES      = 10;
  localparam int          PHASE_ITEMS = 188;
  localparam logic [5:0]  PHASE_THRESHOLDS [PHASES] = '{
    6'd2, 6'd7, 6'd0, 6'd12, 6'd45, 6'd3, 6'd63, 6'd20, 6'd1, 6'd9
  };

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   checked;
  int   cycles;
  int   sent;
  int   settings;
  int   steady_items;
  int   p, k, stall;

  apn_pix_if pix ();
  apn_res_if res ();
  apn_cfg_if cfg ();

  adaptive_palette_nearest_pen #(.PALETTE_ENTRIES(ENTRIES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix),
    .out_ch (res),
    .cfg_ch (cfg)
  );

  palette_match_checker #(.PALETTE_ENTRIES(ENTRIES)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix),
    .res         (res),
    .cfg         (cfg),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d items still outstanding", $time, outstanding);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 15);
    return $urandom_range(40, 120);
  endfunction

  function automatic color_t random_shade();
    color_t c;
    int     roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      c = {4'($urandom_range(0, 7)), 4'($urandom_range(0, 7)), 4'($urandom_range(0, 7))};
    end else if (roll < 45) begin
      c.r = $urandom_range(0, 1) ? 4'hF : 4'h0;
      c.g = $urandom_range(0, 1) ? 4'hF : 4'h0;
      c.b = $urandom_range(0, 1) ? 4'hF : 4'h0;
    end else begin
      c = 12'($urandom_range(0, 4095));
    end
    return c;
  endfunction

  // result side: short stalls mostly, occasional long ones and long open stretches
  initial begin
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) begin
        res.ready <= 1'b1;
        repeat ($urandom_range(100, 300)) @(posedge clk);
      end
      stall = idle_len();
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y, input color_t c);
    int gap;
    if (steady_items > 0) begin
      steady_items--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) steady_items = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= x;
    pix.pixel_y <= y;
    pix.red     <= c.r;
    pix.green   <= c.g;
    pix.blue    <= c.b;
    do @(posedge clk); while (!pix.ready);
    sent++;
  endtask

  task automatic random_pixel();
    send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), random_shade());
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [5:0] value);
    drain();
    cfg.valid           <= 1'b1;
    cfg.match_threshold <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    settings++;
  endtask

  initial begin
    rst_n               <= 1'b0;
    pix.valid           <= 1'b0;
    pix.pixel_x         <= '0;
    pix.pixel_y         <= '0;
    pix.red             <= '0;
    pix.green           <= '0;
    pix.blue            <= '0;
    cfg.valid           <= 1'b0;
    cfg.match_threshold <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty palette with the top threshold: nothing gets allocated
    set_threshold(6'd63);
    send_pixel(10'd0, 10'd0, {4'd0, 4'd0, 4'd0});
    send_pixel(10'd1023, 10'd1023, {4'd15, 4'd15, 4'd15});

    set_threshold(6'd45);
    send_pixel(10'd512, 10'd1, {4'd3, 4'd5, 4'd7});
    send_pixel(10'd1, 10'd512, {4'd3, 4'd5, 4'd7});
    send_pixel(10'd1023, 10'd0, {4'd6, 4'd10, 4'd14});
    send_pixel(10'd0, 10'd1023, {4'd15, 4'd0, 4'd0});
    send_pixel(10'd341, 10'd682, {4'd0, 4'd15, 4'd15});

    // every miss allocates; ties and half-brite hits
    set_threshold(6'd0);
    send_pixel(10'd682, 10'd341, {4'd15, 4'd15, 4'd15});
    send_pixel(10'd0, 10'd0, {4'd0, 4'd0, 4'd0});
    send_pixel(10'd1023, 10'd1023, {4'd0, 4'd0, 4'd0});
    send_pixel(10'd100, 10'd200, {4'd7, 4'd7, 4'd7});
    send_pixel(10'd300, 10'd400, {4'd8, 4'd0, 4'd0});
    send_pixel(10'd500, 10'd600, {4'd1, 4'd1, 4'd1});
    send_pixel(10'd700, 10'd800, {4'd1, 4'd1, 4'd1});
    send_pixel(10'd900, 10'd15, {4'd7, 4'd8, 4'd7});
    send_pixel(10'd31, 10'd992, {4'd15, 4'd15, 4'd0});
    send_pixel(10'd992, 10'd31, {4'd4, 4'd2, 4'd1});

    for (p = 0; p < PHASES; p++) begin
      set_threshold(PHASE_THRESHOLDS[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && p % 3 == 1) drain();
        random_pixel();
      end
    end

    drain();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("Sent %0d pixels under %0d threshold settings (0 through 63), %0d results checked,",
             sent, settings, checked);
    $display("from an empty palette through a full one, with stalls on both channels.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
